// ===== rtl/core/fca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants for the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ENTRY_W    = 32;

	localparam logic [ENTRY_W-1:0] CHAIN_END  = 32'hFFFF_FFFF;
	localparam logic [ENTRY_W-1:0] ENTRY_FREE = 32'h0000_0000;

	// command codes; code 3 is rejected
	typedef enum logic [1:0] {
		CMD_FORMAT = 2'd0,
		CMD_ALLOC  = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_BAD   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COUNT,
		ST_LINK,
		ST_TERM,
		ST_HINT
	} state_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CNT_W-1:0] block_count;
		logic [IDX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [IDX_W-1:0]   first_block;
		logic [ENTRY_W-1:0] entry_value;
	} rsp_t;

endpackage

// ===== rtl/core/fat_chain_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Allocation table of block chains kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; req carries
//   cmd, block_count and entry_index. Every transaction gives exactly one
//   response on rsp, marked by done for a single cycle. The receiver cannot
//   stall, so rsp must be captured in that cycle.
//   cfg_we/cfg_wdata write total_blocks (clamped to 2..MAX_BLOCKS); write it
//   only while busy is low and no response is pending.
// Sequence per command:
//   read          : one RAM read, then the response.
//   rejected cmd  : response in the cycle after accept.
//   format        : one RAM entry cleared per cycle, over all MAX_BLOCKS.
//   allocate      : a counting scan from the hint, a linking scan, then
//                   a hint scan, one entry per cycle through the single
//                   RAM read port.
// Reset:
//   After arst_n rises the block runs a clearing pass (busy high, no
//   response) that formats the table at full size.
// ----------------------------------------------------------------------------
module fat_chain_allocator
	import fca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;       // next RAM address to read / clear
	logic             vld_s1, vld_d;      // a scan read is returning
	logic [IDX_W-1:0] idx_s1, idx_d;      // address of the returning read
	logic [CNT_W-1:0] found_q, found_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] prev_q, prev_d;     // tail of the chain being built
	logic [IDX_W-1:0] first_q, first_d;
	logic [CNT_W-1:0] hint_q, hint_d;
	logic [CNT_W-1:0] free_q, free_d;
	logic [CNT_W-1:0] tclr_q, tclr_d;     // size used by the clearing pass
	logic             ack_q, ack_d;       // clearing pass owes a response
	logic [CNT_W-1:0] total_q;
	logic             done_q, done_d;
	rsp_t             rsp_q, rsp_d;

	// RAM port
	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	logic [CNT_W-1:0] t_eff;
	logic             can_rd, hit, drained;
	logic [CNT_W-1:0] found_inc;

	fca_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// effective table size
	always_comb begin
		if (total_q < CNT_W'(2)) begin
			t_eff = CNT_W'(2);
		end else if (total_q > CNT_W'(MAX_BLOCKS)) begin
			t_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			t_eff = total_q;
		end
	end

	assign can_rd    = (ptr_q < t_eff);
	assign hit       = vld_s1 && (mem_rdata == ENTRY_FREE);
	assign drained   = !vld_s1 && !can_rd;
	assign found_inc = found_q + CNT_W'(1);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// next state and datapath
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		vld_d     = 1'b0;
		idx_d     = idx_s1;
		found_d   = found_q;
		count_d   = count_q;
		prev_d    = prev_q;
		first_d   = first_q;
		hint_d    = hint_q;
		free_d    = free_q;
		tclr_d    = tclr_q;
		ack_d     = ack_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		mem_we    = 1'b0;
		mem_waddr = prev_q;
		mem_wdata = CHAIN_END;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[IDX_W-1:0];

		// sequential scan: one read issued per cycle while below the size
		if (state_q == ST_COUNT || state_q == ST_LINK || state_q == ST_HINT) begin
			if (can_rd) begin
				mem_re = 1'b1;
				ptr_d  = ptr_q + CNT_W'(1);
				vld_d  = 1'b1;
				idx_d  = ptr_q[IDX_W-1:0];
			end
		end

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.cmd)
						CMD_FORMAT: begin
							state_d = ST_CLEAR;
							ptr_d   = '0;
							tclr_d  = t_eff;
							ack_d   = 1'b1;
						end
						CMD_ALLOC: begin
							if (req.block_count == '0) begin
								done_d = 1'b1;
								rsp_d  = '{STAT_BAD, '0, '0};
							end else if (req.block_count > free_q) begin
								done_d = 1'b1;
								rsp_d  = '{STAT_SHORT, '0, '0};
							end else begin
								state_d = ST_COUNT;
								ptr_d   = hint_q;
								found_d = '0;
								count_d = req.block_count;
							end
						end
						CMD_READ: begin
							if ({1'b0, req.entry_index} >= t_eff) begin
								done_d = 1'b1;
								rsp_d  = '{STAT_BAD, '0, '0};
							end else begin
								mem_re    = 1'b1;
								mem_raddr = req.entry_index;
								state_d   = ST_READ;
							end
						end
						default: begin
							done_d = 1'b1;
							rsp_d  = '{STAT_BAD, '0, '0};
						end
					endcase
				end
			end
			ST_READ: begin
				done_d  = 1'b1;
				rsp_d   = '{STAT_OK, '0, mem_rdata};
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[IDX_W-1:0];
				mem_wdata = (ptr_q == '0 || ptr_q == tclr_q - CNT_W'(1)) ?
					CHAIN_END : ENTRY_FREE;
				if (ptr_q == CNT_W'(MAX_BLOCKS - 1)) begin
					state_d = ST_IDLE;
					hint_d  = CNT_W'(1);
					free_d  = tclr_q - CNT_W'(2);
					ack_d   = 1'b0;
					if (ack_q) begin
						done_d = 1'b1;
						rsp_d  = '{STAT_OK, '0, '0};
					end
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			ST_COUNT: begin
				// dry run: confirm enough free blocks lie ahead of the hint
				if (hit) begin
					found_d = found_inc;
				end
				if (hit && found_inc == count_q) begin
					state_d = ST_LINK;
					ptr_d   = hint_q;
					vld_d   = 1'b0;
					found_d = '0;
				end else if (drained) begin
					done_d  = 1'b1;
					rsp_d   = '{STAT_SHORT, '0, '0};
					state_d = ST_IDLE;
				end
			end
			ST_LINK: begin
				// link each free block found into the tail of the chain
				if (hit) begin
					if (found_q == '0) begin
						first_d = idx_s1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = prev_q;
						mem_wdata = {{(ENTRY_W-IDX_W){1'b0}}, idx_s1};
					end
					prev_d  = idx_s1;
					found_d = found_inc;
					if (found_inc == count_q) begin
						state_d = ST_TERM;
						vld_d   = 1'b0;
					end
				end
			end
			ST_TERM: begin
				mem_we    = 1'b1;
				mem_waddr = prev_q;
				mem_wdata = CHAIN_END;
				ptr_d     = {1'b0, prev_q} + CNT_W'(1);
				vld_d     = 1'b0;
				free_d    = free_q - count_q;
				state_d   = ST_HINT;
			end
			ST_HINT: begin
				if (hit) begin
					hint_d  = {1'b0, idx_s1};
					done_d  = 1'b1;
					rsp_d   = '{STAT_OK, first_q, '0};
					state_d = ST_IDLE;
				end else if (drained) begin
					hint_d  = t_eff;
					done_d  = 1'b1;
					rsp_d   = '{STAT_OK, first_q, '0};
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= '0;
			count_q <= '0;
			prev_q  <= '0;
			first_q <= '0;
			hint_q  <= CNT_W'(1);
			free_q  <= CNT_W'(MAX_BLOCKS - 2);
			tclr_q  <= CNT_W'(MAX_BLOCKS);
			ack_q   <= 1'b0;
			total_q <= CNT_W'(MAX_BLOCKS);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			vld_s1  <= vld_d;
			found_q <= found_d;
			count_q <= count_d;
			prev_q  <= prev_d;
			first_q <= first_d;
			hint_q  <= hint_d;
			free_q  <= free_d;
			tclr_q  <= tclr_d;
			ack_q   <= ack_d;
			done_q  <= done_d;
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
		end
	end

	// response payload and returning scan address, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= idx_d;
		rsp_q  <= rsp_d;
	end

	// ---------------------------------------------------------------- checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_READ || state_q == ST_COUNT) |-> !mem_we)
		else $error("table written outside a format or link phase");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != STAT_OK) |-> (rsp.first_block == '0 && rsp.entry_value == '0))
		else $error("failed response carries data");

	a_link_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> (found_q < count_q))
		else $error("chain longer than requested");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(MAX_BLOCKS - 2))
		else $error("free counter out of range");

	a_hint_after_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HINT && hit) |=> (hint_q > {1'b0, prev_q}))
		else $error("hint not beyond chain tail");

endmodule

// ===== rtl/core/fca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== verif/fat_chain_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator_test
// Self-checking bench for the chain allocator. A scoreboard keeps its own
// copy of the table, search hint and free counter and predicts every
// response. Stimulus is a short directed run (table ends, zero count,
// shortage, exhaustion, resize without format) followed by random
// traffic over a range of table sizes, from the clamped minimum up to the
// full table.
// ----------------------------------------------------------------------------
module fat_chain_allocator_test
	import fca_pkg::*;
();

	localparam int          CYCLE_LIMIT = 6_000_000;
	localparam logic [1:0]  CMD_UNKNOWN = 2'd3;   // no such command, must be rejected
	localparam int          PHASE_ITEMS = 43;
	localparam int          MAX_REPORTS = 60;

	// --------------------------------------------------------------------
	// clock, reset, block I/O
	// --------------------------------------------------------------------
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	req_t             req       = '0;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	always #10 clk = ~clk;

	fat_chain_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// --------------------------------------------------------------------
	// scoreboard copy of the allocator state
	// --------------------------------------------------------------------
	logic [ENTRY_W-1:0] shadow_fat [MAX_BLOCKS];
	int unsigned        shadow_hint;
	int unsigned        shadow_free;
	logic [CNT_W-1:0]   shadow_size = CNT_W'(MAX_BLOCKS);

	req_t cmd_backlog [$];   // transactions waiting for the driver
	rsp_t awaited_rsp [$];   // predicted responses, oldest first
	int   mismatches  = 0;
	int   cycle_count = 0;

	// table size actually in force: register clamped to 2..MAX_BLOCKS
	function automatic int unsigned shadow_span();
		int unsigned t;
		t = shadow_size;
		if (t < 2) t = 2;
		if (t > MAX_BLOCKS) t = MAX_BLOCKS;
		return t;
	endfunction

	function automatic void shadow_format();
		int unsigned t;
		t = shadow_span();
		for (int i = 0; i < MAX_BLOCKS; i++) shadow_fat[i] = ENTRY_FREE;
		shadow_fat[0]   = CHAIN_END;
		shadow_fat[t-1] = CHAIN_END;
		shadow_hint     = 1;
		shadow_free     = t - 2;
	endfunction

	// first free entry at or after 'from', or the table size if none
	function automatic int unsigned shadow_scan(int unsigned from);
		int unsigned t;
		t = shadow_span();
		for (int unsigned i = from; i < t; i++)
			if (shadow_fat[i] == ENTRY_FREE) return i;
		return t;
	endfunction

	// applies one command to the shadow state, returns the response it gives
	function automatic rsp_t table_outcome(req_t r);
		rsp_t        o;
		int unsigned t, n, got, prev, head, nx;
		o = '0;
		t = shadow_span();
		n = r.block_count;
		case (r.cmd)
			CMD_FORMAT: shadow_format();
			CMD_ALLOC: begin
				if (n == 0) begin
					o.status = STAT_BAD;
				end else if (n > shadow_free) begin
					o.status = STAT_SHORT;
				end else begin
					// the counter can be stale after a resize: confirm by a forward count
					got = 0;
					for (int unsigned i = shadow_hint; i < t && got < n; i++)
						if (shadow_fat[i] == ENTRY_FREE) got++;
					if (got < n) begin
						o.status = STAT_SHORT;
					end else begin
						head = shadow_scan(shadow_hint);
						prev = head;
						for (got = 1; got < n; got++) begin
							nx = shadow_scan(prev + 1);
							shadow_fat[prev] = nx;
							prev = nx;
						end
						shadow_fat[prev] = CHAIN_END;
						shadow_hint = shadow_scan(prev + 1);   // table size when exhausted
						shadow_free -= n;
						o.first_block = head[IDX_W-1:0];
					end
				end
			end
			CMD_READ: begin
				if (r.entry_index < t) o.entry_value = shadow_fat[r.entry_index];
				else o.status = STAT_BAD;
			end
			default: o.status = STAT_BAD;
		endcase
		return o;
	endfunction

	// --------------------------------------------------------------------
	// driver: bursts of transactions with random gaps; prediction is made
	// at the edge that accepts the transaction
	// --------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (start && !busy) begin
			awaited_rsp.push_back(table_outcome(req));
			void'(cmd_backlog.pop_front());
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				// a quarter of the bursts run straight into the next one
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			end
		end
		if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (cmd_backlog.size() > 0) begin
			start <= 1'b1;
			req   <= cmd_backlog[0];   // held unchanged until accepted
		end else begin
			start <= 1'b0;
		end
	end

	// --------------------------------------------------------------------
	// monitor: every done pulse must match the oldest prediction
	// --------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (done === 1'b1) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response with nothing awaited, actual %h", $time, rsp);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
				end
				if (rsp.first_block !== want.first_block) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: first_block expected %0d actual %0d",
							$time, want.first_block, rsp.first_block);
				end
				if (rsp.entry_value !== want.entry_value) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: entry_value expected %h actual %h",
							$time, want.entry_value, rsp.entry_value);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------
	function automatic req_t make_req(logic [1:0] c, int unsigned n, int unsigned i);
		req_t r;
		r.cmd         = c;
		r.block_count = n[CNT_W-1:0];
		r.entry_index = i[IDX_W-1:0];
		return r;
	endfunction

	// random transaction, shaped by the current shadow state so that chains
	// build up, the table fills, and shortages and exhaustion occur
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick, t;
		t                = shadow_span();
		r.cmd            = CMD_ALLOC;
		// unused fields carry noise
		r.block_count    = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
		r.entry_index    = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
		pick             = $urandom_range(0, 99);
		if (pick < 6) begin
			r.cmd = CMD_FORMAT;
		end else if (pick < 10) begin
			r.cmd = CMD_UNKNOWN;
		end else if (pick < 32) begin
			r.cmd = CMD_READ;
			if ($urandom_range(0, 1) == 0) r.entry_index = IDX_W'($urandom_range(0, t - 1));
		end else begin
			case ($urandom_range(0, 9))
				0: r.block_count = '0;
				1: r.block_count = CNT_W'(shadow_free + 1);     // just short
				2: ;                                              // any count
				3: r.block_count = CNT_W'(shadow_free);          // take all that is left
				default: r.block_count = CNT_W'($urandom_range(1, shadow_free / 4 + 1));
			endcase
		end
		return r;
	endfunction

	// pushed at the falling edge so the driver never sees a half-updated queue
	task automatic feed(req_t r);
		@(negedge clk);
		while (cmd_backlog.size() >= 2) @(negedge clk);
		cmd_backlog.push_back(r);
	endtask

	// every transaction gives a response, so idle means nothing queued,
	// nothing awaited and the block not busy
	task automatic wait_quiet();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || start || awaited_rsp.size() != 0 || busy);
	endtask

	task automatic set_size(logic [CNT_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		shadow_size  = v;
		@(posedge clk);
		cfg_we      <= 1'b0;
	endtask

	// --------------------------------------------------------------------
	// test sequence
	// --------------------------------------------------------------------
	logic [CNT_W-1:0] sizes [13] = '{11'd2, 11'd0, 11'd1, 11'd3, 11'd5, 11'd16, 11'd37,
		11'd2047, 11'd8, 11'd64, 11'd200, 11'd1023, 11'd1024};

	initial begin
		shadow_format();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, full-size table straight out of the clearing pass
		set_size(CNT_W'(MAX_BLOCKS));
		feed(make_req(CMD_READ, 0, 0));          // reserved head
		feed(make_req(CMD_READ, 0, 1023));       // reserved tail
		feed(make_req(CMD_READ, 0, 1));          // free
		feed(make_req(CMD_ALLOC, 0, 0));         // zero count rejected
		feed(make_req(CMD_UNKNOWN, 0, 0));
		feed(make_req(CMD_ALLOC, 1023, 0));      // one more than free
		feed(make_req(CMD_ALLOC, 2047, 1023));
		feed(make_req(CMD_ALLOC, 1, 0));
		feed(make_req(CMD_ALLOC, 3, 0));
		feed(make_req(CMD_READ, 0, 3));          // middle of a chain
		feed(make_req(CMD_ALLOC, 1018, 0));      // takes the rest, hint runs off the end
		feed(make_req(CMD_READ, 0, 1022));
		feed(make_req(CMD_ALLOC, 1, 0));
		feed(make_req(CMD_FORMAT, 0, 0));
		feed(make_req(CMD_READ, 0, 1022));

		// counter says enough, forward scan says no: shrink without a format
		set_size(11'd16);
		feed(make_req(CMD_FORMAT, 0, 0));
		feed(make_req(CMD_ALLOC, 3, 0));
		set_size(11'd8);
		feed(make_req(CMD_ALLOC, 5, 0));
		feed(make_req(CMD_READ, 0, 8));          // beyond the shrunk table
		feed(make_req(CMD_READ, 0, 7));

		// random traffic over a sweep of sizes; some phases keep the old table
		foreach (sizes[p]) begin
			set_size(sizes[p]);
			if ($urandom_range(0, 3) != 0) feed(make_req(CMD_FORMAT, 0, 0));
			for (int k = 0; k < PHASE_ITEMS; k++) feed(random_request());
		end

		wait_quiet();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fca_pkg.sv
rtl/core/fca_ram.sv
rtl/core/fat_chain_allocator.sv
verif/fat_chain_allocator_test.sv
